### rtl/core/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes of the sequential list engine
// Command and status codes, field widths and payload types used by the
// channel interfaces and by the control logic.
// ----------------------------------------------------------------------------
package sle_pkg;

	// field widths
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int IDX_W    = 7;
	localparam int COUNT_W  = 7;

	// payload types
	typedef logic        [CMD_W-1:0]    cmd_code_t;
	typedef logic        [POS_W-1:0]    pos_t;
	typedef logic signed [DATA_W-1:0]   word_t;
	typedef logic        [STATUS_W-1:0] status_t;
	typedef logic signed [IDX_W-1:0]    oidx_t;
	typedef logic        [COUNT_W-1:0]  ocount_t;

	// command codes
	localparam cmd_code_t CMD_PUSH_BACK  = 3'd0;
	localparam cmd_code_t CMD_PUSH_FRONT = 3'd1;
	localparam cmd_code_t CMD_POP_BACK   = 3'd2;
	localparam cmd_code_t CMD_POP_FRONT  = 3'd3;
	localparam cmd_code_t CMD_INSERT     = 3'd4;
	localparam cmd_code_t CMD_ERASE      = 3'd5;
	localparam cmd_code_t CMD_FIND       = 3'd6;

	// status codes
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_EMPTY    = 3'd2;
	localparam status_t ST_BADPOS   = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;

	// index reported when nothing was found
	localparam oidx_t NO_INDEX = '1;

endpackage

### rtl/core/sle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cmd_if / sle_rsp_if: command and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sle_cmd_if
	import sle_pkg::*;
	;
	logic      valid;
	logic      ready;
	cmd_code_t cmd;
	pos_t      position;
	word_t     value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface sle_rsp_if
	import sle_pkg::*;
	;
	logic    valid;
	logic    ready;
	status_t status;
	oidx_t   found_index;
	ocount_t entry_count;

	modport source (output valid, output status, output found_index, output entry_count,
		input ready);
	modport sink   (input valid, input status, input found_index, input entry_count,
		output ready);
endinterface

### rtl/core/sle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram: element store
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module sle_ram
	import sle_pkg::*;
#(
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output word_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  word_t         wr_data
);

	word_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl: list sequencer
// Decodes each command beat, walks the store to open or close a gap or to
// search it, keeps the element count and holds the response register.
// ----------------------------------------------------------------------------
module sle_ctrl
	import sle_pkg::*;
#(
	parameter  int CAPACITY = 64,
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	sle_cmd_if.sink       cmd_chan,
	sle_rsp_if.source     rsp_chan,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  word_t         rd_data,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output word_t         wr_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_SHIFT_UP = 6'b000010,
		S_FILL     = 6'b000100,
		S_SHIFT_DN = 6'b001000,
		S_SEARCH   = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] idx_q, idx_d;
	word_t         val_q, val_d;
	status_t       status_q, status_d;
	oidx_t         found_q, found_d;
	logic          rsp_valid_q, rsp_valid_d;
	status_t       rsp_status_q, rsp_status_d;
	oidx_t         rsp_found_q, rsp_found_d;
	ocount_t       rsp_count_q, rsp_count_d;

	logic          full, empty;
	logic [XW-1:0] cnt_x, pos_x;
	logic          ins_ok, ers_ok;
	logic [AW-1:0] pos_a, cnt_a, last_a;
	logic [AW-1:0] open_idx, close_idx;
	logic          open_ok, close_ok;

	// checks on the incoming beat against the current count
	always_comb begin
		full      = (count_q == CW'(CAPACITY));
		empty     = (count_q == '0);
		cnt_x     = XW'(count_q);
		pos_x     = XW'(cmd_chan.position);
		ins_ok    = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
		ers_ok    = (pos_x != '0) && (pos_x <= cnt_x);
		pos_a     = AW'(pos_x - 1'b1);
		cnt_a     = AW'(count_q);
		last_a    = AW'(count_q - 1'b1);
		open_idx  = (cmd_chan.cmd == CMD_INSERT) ? pos_a : '0;
		open_ok   = (cmd_chan.cmd == CMD_PUSH_FRONT) || ins_ok;
		close_idx = (cmd_chan.cmd == CMD_ERASE) ? pos_a : '0;
		close_ok  = (cmd_chan.cmd == CMD_POP_FRONT) || ers_ok;
	end

	assign cmd_chan.ready       = (state_q == S_IDLE);
	assign rsp_chan.valid       = rsp_valid_q;
	assign rsp_chan.status      = rsp_status_q;
	assign rsp_chan.found_index = rsp_found_q;
	assign rsp_chan.entry_count = rsp_count_q;

	// sequencer and store access
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		cur_d        = cur_q;
		idx_d        = idx_q;
		val_d        = val_q;
		status_d     = status_q;
		found_d      = found_q;
		rsp_valid_d  = rsp_valid_q && !rsp_chan.ready;
		rsp_status_d = rsp_status_q;
		rsp_found_d  = rsp_found_q;
		rsp_count_d  = rsp_count_q;
		rd_en        = 1'b0;
		rd_addr      = cur_q;
		wr_en        = 1'b0;
		wr_addr      = cur_q;
		wr_data      = val_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_chan.valid) begin
					val_d    = cmd_chan.value;
					status_d = ST_OK;
					found_d  = NO_INDEX;
					state_d  = S_DONE;
					case (cmd_chan.cmd) inside
						CMD_PUSH_BACK: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = cnt_a;
								wr_data = cmd_chan.value;
								count_d = count_q + 1'b1;
							end
						end
						CMD_PUSH_FRONT, CMD_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
							end else if (!open_ok) begin
								status_d = ST_BADPOS;
							end else begin
								idx_d = open_idx;
								if (open_idx == cnt_a) begin
									// slot at the tail, nothing to move
									wr_en   = 1'b1;
									wr_addr = open_idx;
									wr_data = cmd_chan.value;
									count_d = count_q + 1'b1;
								end else begin
									rd_en   = 1'b1;
									rd_addr = cnt_a - 1'b1;
									cur_d   = cnt_a;
									state_d = S_SHIFT_UP;
								end
							end
						end
						CMD_POP_BACK: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						CMD_POP_FRONT, CMD_ERASE: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else if (!close_ok) begin
								status_d = ST_BADPOS;
							end else if (close_idx == last_a) begin
								// last element goes, nothing to move
								count_d = count_q - 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = close_idx + 1'b1;
								cur_d   = close_idx;
								state_d = S_SHIFT_DN;
							end
						end
						CMD_FIND: begin
							if (empty) begin
								status_d = ST_NOTFOUND;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								cur_d   = '0;
								state_d = S_SEARCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT_UP: begin
				// move one word up a slot, read the one below it
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = rd_data;
				if (cur_q - 1'b1 == idx_q) begin
					state_d = S_FILL;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_q - AW'(2);
					cur_d   = cur_q - 1'b1;
				end
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = val_q;
				count_d = count_q + 1'b1;
				state_d = S_DONE;
			end
			S_SHIFT_DN: begin
				// move one word down a slot, read the one above it
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = rd_data;
				if (cur_q + 1'b1 == last_a) begin
					count_d = count_q - 1'b1;
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_q + AW'(2);
					cur_d   = cur_q + 1'b1;
				end
			end
			S_SEARCH: begin
				// compare the word read last cycle, fetch the next
				if (rd_data == val_q) begin
					status_d = ST_OK;
					found_d  = IDX_W'(cur_q);
					state_d  = S_DONE;
				end else if (cur_q == last_a) begin
					status_d = ST_NOTFOUND;
					state_d  = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_q + 1'b1;
					cur_d   = cur_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_chan.ready) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = status_q;
					rsp_found_d  = found_q;
					rsp_count_d  = COUNT_W'(count_q);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// working and response payload
	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		idx_q        <= idx_d;
		val_q        <= val_d;
		status_q     <= status_d;
		found_q      <= found_d;
		rsp_status_q <= rsp_status_d;
		rsp_found_q  <= rsp_found_d;
		rsp_count_q  <= rsp_count_d;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write of the same slot in one cycle");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_chan.valid && (rsp_chan.found_index != NO_INDEX)) |-> (rsp_chan.status == ST_OK))
		else $error("index reported without ok status");

	a_find_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_chan.valid && cmd_chan.ready && (cmd_chan.cmd == CMD_FIND))
		|=> (count_q == $past(count_q)))
		else $error("find changed the element count");
`endif

endmodule

### rtl/core/sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine: packed ordered list of signed 32-bit words
// Push, pop, insert, erase and find over a RAM-backed list of CAPACITY words.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and gives one response beat. The list
// lives in a single-port-read, single-port-write RAM with a registered read,
// and every word move or compare goes through that RAM one entry a cycle.
// Push back, pop back, error cases and the unused command code go straight
// from the command to the done state. Push front and insert shift each word
// above the new slot up one place unless the new word lands at the tail; pop
// front and erase shift each word above the gap down one place. A find compares
// entries from the front up to the count and stops at the first match. The next
// command is taken while a response still waits on the output register. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sle_cmd_if.sink   cmd_chan,
	sle_rsp_if.source rsp_chan
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	word_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	word_t         wr_data;

	// sequencer
	sle_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_chan (cmd_chan),
		.rsp_chan (rsp_chan),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// element store
	sle_ram #(
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

### tb/tb_sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine: self-checking bench for the list engine
// Drives command beats through the valid/ready channel and keeps a shadow copy
// of the packed list. Every accepted command is turned into an awaited
// response, which is compared field by field against the response beats.
// Directed edge cases come first, then random traffic that swings between
// growing and shrinking the list, under several idling and stalling phases.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;
	import sle_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 100;
	localparam int ITEMS_PER_PHASE = 100;

	// spare command code that the engine ignores
	localparam cmd_code_t CMD_UNUSED = 3'd7;

	typedef struct packed {
		status_t status;
		oidx_t   found_index;
		ocount_t entry_count;
	} rsp_beat_t;

	// traffic mix of the random part
	typedef enum {MIX_BALANCED, MIX_GROW, MIX_SHRINK} mix_t;

	// shadow list and queue of awaited responses
	class list_checker;
		word_t       shadow_words[$];
		rsp_beat_t   awaited_rsp[$];
		int unsigned error_count;

		function new();
			error_count = 0;
		endfunction

		function int list_len();
			return shadow_words.size();
		endfunction

		function word_t word_at(int k);
			return shadow_words[k];
		endfunction

		function int pending();
			return awaited_rsp.size();
		endfunction

		// apply one command to the shadow list and queue its response
		function void note_command(cmd_code_t cmd, pos_t pos, word_t val);
			status_t   st;
			oidx_t     idx;
			int        n;
			int        slot;
			rsp_beat_t beat;
			st = ST_OK;
			idx = NO_INDEX;
			n = shadow_words.size();
			slot = int'(pos);
			case (cmd)
				CMD_PUSH_BACK: begin
					if (n >= LIST_DEPTH) st = ST_FULL;
					else shadow_words.push_back(val);
				end
				CMD_PUSH_FRONT: begin
					if (n >= LIST_DEPTH) st = ST_FULL;
					else shadow_words.push_front(val);
				end
				CMD_POP_BACK: begin
					if (n == 0) st = ST_EMPTY;
					else void'(shadow_words.pop_back());
				end
				CMD_POP_FRONT: begin
					if (n == 0) st = ST_EMPTY;
					else void'(shadow_words.pop_front());
				end
				CMD_INSERT: begin
					// full is reported ahead of a bad position
					if (n >= LIST_DEPTH) st = ST_FULL;
					else if (slot < 1 || slot > n + 1) st = ST_BADPOS;
					else shadow_words.insert(slot - 1, val);
				end
				CMD_ERASE: begin
					// empty is reported ahead of a bad position
					if (n == 0) st = ST_EMPTY;
					else if (slot < 1 || slot > n) st = ST_BADPOS;
					else shadow_words.delete(slot - 1);
				end
				CMD_FIND: begin
					st = ST_NOTFOUND;
					for (int k = 0; k < n; k++) begin
						if (shadow_words[k] == val) begin
							st = ST_OK;
							idx = oidx_t'(k);
							break;
						end
					end
				end
				default: begin
				end
			endcase
			beat.status = st;
			beat.found_index = idx;
			beat.entry_count = ocount_t'(shadow_words.size());
			awaited_rsp.push_back(beat);
		endfunction

		// compare one response beat with the oldest awaited one
		function void check_response(status_t st, oidx_t idx, ocount_t cnt);
			rsp_beat_t want;
			if (awaited_rsp.size() == 0) begin
				$error("response beat with no command waiting");
				error_count++;
				return;
			end
			want = awaited_rsp.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				error_count++;
			end
			if (idx !== want.found_index) begin
				$error("found_index: expected %0d, got %0d", want.found_index, idx);
				error_count++;
			end
			if (cnt !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
				error_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          send_idle_pct;
	int          rsp_stall_pct;
	bit          hold_request;
	int          hold_left;
	int          cycle_count;
	mix_t        mix;
	list_checker lists;

	sle_cmd_if cmd_chan ();
	sle_rsp_if rsp_chan ();

	sequential_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_chan(cmd_chan),
		.rsp_chan(rsp_chan)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// response ready: long hold-off on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			rsp_chan.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_chan.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	// beat monitors on both channels
	always @(posedge clk) begin
		if (arst_n && cmd_chan.valid && cmd_chan.ready)
			lists.note_command(cmd_chan.cmd, cmd_chan.position, cmd_chan.value);
		if (arst_n && rsp_chan.valid && rsp_chan.ready)
			lists.check_response(rsp_chan.status, rsp_chan.found_index,
				rsp_chan.entry_count);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sequential_list_engine failed");
		$finish;
	end

	// offer one command beat and wait until it is taken
	task automatic send_cmd(cmd_code_t c, pos_t p, word_t v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_chan.valid = 1'b0;
			@(negedge clk);
		end
		cmd_chan.valid = 1'b1;
		cmd_chan.cmd = c;
		cmd_chan.position = p;
		cmd_chan.value = v;
		do @(posedge clk); while (!cmd_chan.ready);
		@(negedge clk);
	endtask

	// stop offering and wait for every awaited response
	task automatic wait_drained();
		cmd_chan.valid = 1'b0;
		while (lists.pending() != 0)
			@(negedge clk);
	endtask

	// command choice weighted by the current mix
	function automatic cmd_code_t pick_cmd(mix_t m, int r);
		case (m)
			MIX_GROW: begin
				if (r < 35) return CMD_PUSH_BACK;
				if (r < 55) return CMD_PUSH_FRONT;
				if (r < 80) return CMD_INSERT;
				if (r < 85) return CMD_POP_BACK;
				if (r < 88) return CMD_POP_FRONT;
				if (r < 91) return CMD_ERASE;
				if (r < 99) return CMD_FIND;
			end
			MIX_SHRINK: begin
				if (r < 25) return CMD_POP_BACK;
				if (r < 45) return CMD_POP_FRONT;
				if (r < 75) return CMD_ERASE;
				if (r < 80) return CMD_PUSH_BACK;
				if (r < 83) return CMD_INSERT;
				if (r < 98) return CMD_FIND;
			end
			default: begin
				if (r < 15) return CMD_PUSH_BACK;
				if (r < 28) return CMD_PUSH_FRONT;
				if (r < 39) return CMD_POP_BACK;
				if (r < 50) return CMD_POP_FRONT;
				if (r < 65) return CMD_INSERT;
				if (r < 80) return CMD_ERASE;
				if (r < 98) return CMD_FIND;
			end
		endcase
		return CMD_UNUSED;
	endfunction

	// one random command, mostly with legal positions, sometimes with known or extreme words
	task automatic send_random();
		int        n;
		int        r;
		cmd_code_t c;
		pos_t      p;
		word_t     v;
		n = lists.list_len();
		// swing between filling to full and draining to empty
		if (mix == MIX_GROW && n == LIST_DEPTH && $urandom_range(0, 3) == 0)
			mix = MIX_SHRINK;
		else if (mix == MIX_SHRINK && n == 0 && $urandom_range(0, 3) == 0)
			mix = MIX_BALANCED;
		else if (mix == MIX_BALANCED && $urandom_range(0, 39) == 0)
			mix = MIX_GROW;
		c = pick_cmd(mix, $urandom_range(0, 99));
		if ($urandom_range(0, 9) < 8) begin
			if (c == CMD_ERASE)
				p = pos_t'($urandom_range(1, (n > 0) ? n : 1));
			else
				p = pos_t'($urandom_range(1, n + 1));
		end else begin
			p = pos_t'($urandom_range(0, 127));
		end
		r = $urandom_range(0, 9);
		if (r < 2 && n > 0) begin
			v = lists.word_at($urandom_range(0, n - 1));
		end else if (r < 3) begin
			case ($urandom_range(0, 3))
				0: v = 32'sh0000_0000;
				1: v = -32'sd1;
				2: v = 32'sh8000_0000;
				default: v = 32'sh7FFF_FFFF;
			endcase
		end else begin
			v = word_t'($urandom);
		end
		send_cmd(c, p, v);
	endtask

	// main sequence
	initial begin
		lists = new();
		arst_n = 1'b0;
		cmd_chan.valid = 1'b0;
		cmd_chan.cmd = CMD_PUSH_BACK;
		cmd_chan.position = '0;
		cmd_chan.value = '0;
		rsp_chan.ready = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_request = 1'b0;
		hold_left = 0;
		mix = MIX_GROW;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list: pops, erases and find
		send_cmd(CMD_POP_BACK, 7'd0, 32'sh0);
		send_cmd(CMD_POP_FRONT, 7'd0, 32'sh0);
		send_cmd(CMD_ERASE, 7'd1, 32'sh0);
		send_cmd(CMD_ERASE, 7'd0, 32'sh0);
		send_cmd(CMD_FIND, 7'd0, 32'sh0);
		// insert positions off either end
		send_cmd(CMD_INSERT, 7'd0, 32'sh1);
		send_cmd(CMD_INSERT, 7'd2, 32'sh1);
		// build a short list with extreme words and a duplicate
		send_cmd(CMD_INSERT, 7'd1, 32'sh7FFF_FFFF);
		send_cmd(CMD_PUSH_BACK, 7'd0, 32'sh8000_0000);
		send_cmd(CMD_PUSH_FRONT, 7'd0, 32'sh0);
		send_cmd(CMD_INSERT, 7'd4, -32'sd1);
		send_cmd(CMD_INSERT, 7'd2, 32'sh5555_5555);
		send_cmd(CMD_PUSH_BACK, 7'd0, 32'sh0);
		// first match, later matches and a miss
		send_cmd(CMD_FIND, 7'd0, 32'sh0);
		send_cmd(CMD_FIND, 7'd0, 32'sh8000_0000);
		send_cmd(CMD_FIND, 7'd0, -32'sd1);
		send_cmd(CMD_FIND, 7'd0, 32'sh1234_5678);
		// spare code is ignored
		send_cmd(CMD_UNUSED, 7'd127, 32'shAAAA_AAAA);
		// bad positions on a non-empty list
		send_cmd(CMD_ERASE, 7'd0, 32'sh0);
		send_cmd(CMD_ERASE, 7'd7, 32'sh0);
		send_cmd(CMD_ERASE, 7'd127, 32'sh0);
		send_cmd(CMD_INSERT, 7'd127, 32'sh0);
		// erase at the last and first slot, then pops
		send_cmd(CMD_ERASE, 7'd6, 32'sh0);
		send_cmd(CMD_ERASE, 7'd1, 32'sh0);
		send_cmd(CMD_POP_FRONT, 7'd0, 32'sh0);
		send_cmd(CMD_POP_BACK, 7'd0, 32'sh0);
		wait_drained();

		// receiver holds off while commands keep coming
		hold_request = 1'b1;

		// random phases with different idling on either side
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 47;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 47;
				end
				default: begin
					send_idle_pct = 38;
					rsp_stall_pct = 38;
				end
			endcase
			repeat (ITEMS_PER_PHASE) send_random();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (lists.error_count == 0 && lists.pending() == 0)
			$display("tb_sequential_list_engine passed");
		else
			$display("tb_sequential_list_engine failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/sle_pkg.sv
rtl/core/sle_if.sv
rtl/core/sle_ram.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine.sv
tb/tb_sequential_list_engine.sv
